// ----- hdl/thp_pkg.sv -----
// shared types, constants and crc function for the thermo-hygro packet decoder
`default_nettype none

package thp_pkg;

  // packet geometry and expected framing
  localparam logic [9:0] PKT_LEN   = 10'd48;
  localparam logic [3:0] ROWS_EXP  = 4'd2;
  localparam int unsigned CRC_BYTES = 5;

  // configuration register reset values
  localparam logic [7:0] CRC_INIT_RST   = 8'h2e;
  localparam logic [7:0] CRC_POLY_RST   = 8'h31;
  localparam logic [7:0] START_BYTE_RST = 8'h00;

  // decode constants
  localparam logic [7:0] HUM_NONE       = 8'hff;
  localparam logic [3:0] SENSOR_ONE_ID  = 4'h7;

  // apb address width and register indexes
  localparam int unsigned ADDR_W = 4;

  typedef enum logic [1:0] {
    REG_CRC_INIT   = 2'd0,
    REG_CRC_POLY   = 2'd1,
    REG_START_BYTE = 2'd2
  } thp_reg_e;

  // error codes, first failing check wins
  typedef enum logic [2:0] {
    ERR_OK    = 3'd0,
    ERR_ROWS  = 3'd1,
    ERR_LEN   = 3'd2,
    ERR_START = 3'd3,
    ERR_CRC   = 3'd4
  } thp_err_e;

  // input transaction payload
  typedef struct packed {
    logic [3:0]  row_count;
    logic [9:0]  bits_in_row;
    logic [47:0] packet_bits;
  } thp_in_t;

  // result transaction payload
  typedef struct packed {
    logic               packet_ok;
    thp_err_e           error_code;
    logic [3:0]         channel;
    logic [1:0]         sensor_number;
    logic signed [11:0] temperature_tenths;
    logic [7:0]         humidity;
    logic               humidity_present;
  } thp_res_t;

  // configuration register set
  typedef struct packed {
    logic [7:0] crc_init;
    logic [7:0] crc_poly;
    logic [7:0] start_byte;
  } thp_cfg_t;

  // data carried down the crc pipeline
  typedef struct packed {
    thp_err_e    err;
    logic [7:0]  crc;
    logic [47:0] pkt;
  } thp_pipe_t;

  // one byte of msb-first crc-8
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc,
                                           input logic [7:0] data,
                                           input logic [7:0] poly);
    logic [7:0] c;
    c = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ poly) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/thermo_hygro_packet_decoder.sv -----
// top level of the thermo-hygro packet decoder
// path: an accepted packet passes the five crc stage registers, then the decode register that drives the result strobe
// throughput: one packet per cycle, busy stays low; five crc stages of one byte each
// plus a compare and decode stage set the depth
// reset: rst_ni clears all valid bits and loads the register reset values
// the result strobe lasts one cycle, the receiver cannot stall
`default_nettype none

module thermo_hygro_packet_decoder (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire thp_pkg::thp_in_t            in_i,
  output logic                             done_o,
  output thp_pkg::thp_res_t                res_o,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [thp_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready
);

  thp_pkg::thp_cfg_t  cfg;
  thp_pkg::thp_pipe_t pipe_s  [thp_pkg::CRC_BYTES+1];
  logic               valid_s [thp_pkg::CRC_BYTES+1];
  thp_pkg::thp_pipe_t pipe_in;
  logic               valid_in;

  // configuration port
  thp_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // pipeline never holds off a transaction
  assign busy = 1'b0;

  // entry: framing checks in priority order, crc seeded
  always_comb begin
    valid_in     = start & ~busy;
    pipe_in.pkt  = in_i.packet_bits;
    pipe_in.crc  = cfg.crc_init;
    if (in_i.row_count != thp_pkg::ROWS_EXP) begin
      pipe_in.err = thp_pkg::ERR_ROWS;
    end else if (in_i.bits_in_row != thp_pkg::PKT_LEN) begin
      pipe_in.err = thp_pkg::ERR_LEN;
    end else if (in_i.packet_bits[47:40] != cfg.start_byte) begin
      pipe_in.err = thp_pkg::ERR_START;
    end else begin
      pipe_in.err = thp_pkg::ERR_OK;
    end
  end

  assign valid_s[0] = valid_in;
  assign pipe_s[0]  = pipe_in;

  // crc stages, one byte each
  for (genvar g = 0; g < thp_pkg::CRC_BYTES; g++) begin : g_crc
    thp_crc_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_s[g]),
      .pipe_i  (pipe_s[g]),
      .byte_i  (pipe_s[g].pkt[47-8*g -: 8]),
      .poly_i  (cfg.crc_poly),
      .valid_o (valid_s[g+1]),
      .pipe_o  (pipe_s[g+1])
    );
  end

  // compare and decode
  thp_decode u_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_s[thp_pkg::CRC_BYTES]),
    .pipe_i  (pipe_s[thp_pkg::CRC_BYTES]),
    .done_o  (done_o),
    .res_o   (res_o)
  );

endmodule

`default_nettype wire

// ----- hdl/thp_cfg_regs.sv -----
// apb configuration registers for the thermo-hygro packet decoder
`default_nettype none

module thp_cfg_regs (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [thp_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready,
  output thp_pkg::thp_cfg_t                cfg_o
);

  thp_pkg::thp_cfg_t cfg_d, cfg_q;
  logic              wr_en;
  logic [1:0]        reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = paddr[3:2];

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        thp_pkg::REG_CRC_INIT:   cfg_d.crc_init   = pwdata[7:0];
        thp_pkg::REG_CRC_POLY:   cfg_d.crc_poly   = pwdata[7:0];
        thp_pkg::REG_START_BYTE: cfg_d.start_byte = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.crc_init   <= thp_pkg::CRC_INIT_RST;
      cfg_q.crc_poly   <= thp_pkg::CRC_POLY_RST;
      cfg_q.start_byte <= thp_pkg::START_BYTE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // read mux
  always_comb begin
    case (reg_idx)
      thp_pkg::REG_CRC_INIT:   prdata = {24'd0, cfg_q.crc_init};
      thp_pkg::REG_CRC_POLY:   prdata = {24'd0, cfg_q.crc_poly};
      thp_pkg::REG_START_BYTE: prdata = {24'd0, cfg_q.start_byte};
      default:                 prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ----- hdl/thp_crc_stage.sv -----
// one pipeline stage folding one packet byte into the running crc
`default_nettype none

module thp_crc_stage (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  input  wire thp_pkg::thp_pipe_t pipe_i,
  input  wire logic [7:0]         byte_i,
  input  wire logic [7:0]         poly_i,
  output logic                    valid_o,
  output thp_pkg::thp_pipe_t      pipe_o
);

  logic               valid_q;
  thp_pkg::thp_pipe_t pipe_d, pipe_q;

  // crc update for this byte
  always_comb begin
    pipe_d     = pipe_i;
    pipe_d.crc = thp_pkg::crc8_byte(pipe_i.crc, byte_i, poly_i);
  end

  // valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  // payload register
  always_ff @(posedge clk_i) begin
    pipe_q <= pipe_d;
  end

  assign valid_o = valid_q;
  assign pipe_o  = pipe_q;

endmodule

`default_nettype wire

// ----- hdl/thp_decode.sv -----
// final stage: crc compare and field decode into the result register
`default_nettype none

module thp_decode (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  input  wire thp_pkg::thp_pipe_t pipe_i,
  output logic                    done_o,
  output thp_pkg::thp_res_t       res_o
);

  logic              done_q;
  thp_pkg::thp_res_t res_d, res_q;
  thp_pkg::thp_err_e err;
  logic [47:0]       inv;
  logic [11:0]       raw_temp;
  logic [11:0]       temp;

  // crc check joins the earlier checks
  always_comb begin
    err = pipe_i.err;
    if (err == thp_pkg::ERR_OK && pipe_i.crc != pipe_i.pkt[7:0]) begin
      err = thp_pkg::ERR_CRC;
    end
  end

  // sign-magnitude temperature to two's complement
  assign inv      = ~pipe_i.pkt;
  assign raw_temp = inv[27:16];
  assign temp     = raw_temp[11] ? (12'd0 - {1'b0, raw_temp[10:0]}) : raw_temp;

  // field decode, all fields zero on error apart from the error code
  always_comb begin
    res_d                    = '0;
    res_d.error_code         = err;
    if (err == thp_pkg::ERR_OK) begin
      res_d.packet_ok          = 1'b1;
      res_d.channel            = {1'b0, inv[34:32]} + 4'd1;
      res_d.sensor_number      = (inv[31:28] == thp_pkg::SENSOR_ONE_ID) ? 2'd1 : 2'd2;
      res_d.temperature_tenths = $signed(temp);
      res_d.humidity           = inv[15:8];
      res_d.humidity_present   = (inv[15:8] != thp_pkg::HUM_NONE);
    end
  end

  // result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_i;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

`default_nettype wire

// ----- hdl/thp_checker.sv -----
// port-level checker for the thermo-hygro packet decoder and its bind
`default_nettype none

module thp_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              done_o,
  input wire thp_pkg::thp_res_t res_o
);

  // every accepted transaction yields a result once it has passed the crc and decode stages
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##6 done_o)
    else $error("missing result after accepted transaction");

  // no result without a matching transaction
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, 6) && !$past(busy, 6))
    else $error("result without accepted transaction");

  // ok flag agrees with the error code
  a_ok_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (res_o.packet_ok == (res_o.error_code == thp_pkg::ERR_OK)))
    else $error("packet_ok disagrees with error_code");

  // failed packets carry zeroed fields
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !res_o.packet_ok |-> res_o.channel == 4'd0 && res_o.sensor_number == 2'd0
      && res_o.temperature_tenths == 12'sd0 && res_o.humidity == 8'd0
      && !res_o.humidity_present)
    else $error("nonzero fields on failed packet");

  // good packets carry valid channel, sensor and humidity flag
  a_ok_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.packet_ok |-> res_o.channel != 4'd0 && res_o.sensor_number != 2'd0
      && res_o.humidity_present == (res_o.humidity != thp_pkg::HUM_NONE))
    else $error("bad decoded fields on good packet");

endmodule

bind thermo_hygro_packet_decoder thp_checker u_thp_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o),
  .res_o  (res_o)
);

`default_nettype wire

// ----- tb/sv/tb_thermo_hygro_packet_decoder.sv -----
// self-checking testbench for the thermo-hygro packet decoder
`default_nettype none

module tb_thermo_hygro_packet_decoder;

  // register index with no register behind it
  localparam int unsigned UNMAPPED_REG  = 3;
  // cycles to let the six stage pipeline settle after the last strobe
  localparam int unsigned SETTLE_CYCLES = 10;
  localparam int unsigned DRAIN_LIMIT   = 2000;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         start;
  logic                         busy;
  thp_pkg::thp_in_t             in_i;
  logic                         done_o;
  thp_pkg::thp_res_t            res_o;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [thp_pkg::ADDR_W-1:0]   paddr;
  logic [31:0]                  pwdata;
  logic [31:0]                  prdata;
  logic                         pready;

  // register copy used by the decoder prediction
  thp_pkg::thp_cfg_t            cfg_model;
  // decoded readings still owed by the block, oldest first
  thp_pkg::thp_res_t            expected_readings[$];
  int unsigned                  mismatch_count;

  thermo_hygro_packet_decoder dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .in_i    (in_i),
    .done_o  (done_o),
    .res_o   (res_o),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // watchdog
  initial begin
    #400000;
    $display("RESULT: ERROR");
    $finish;
  end

  // msb-first crc-8, one bit at a time over the five head bytes
  function automatic logic [7:0] crc_over_head(input logic [39:0] head,
                                               input thp_pkg::thp_cfg_t c);
    logic [7:0] r;
    logic       fb;
    r = c.crc_init;
    for (int i = 39; i >= 0; i--) begin
      fb = r[7] ^ head[i];
      r  = {r[6:0], 1'b0};
      if (fb) begin
        r = r ^ c.crc_poly;
      end
    end
    return r;
  endfunction

  // expected reading for one packet under the given registers
  function automatic thp_pkg::thp_res_t decode_reading(input thp_pkg::thp_in_t p,
                                                       input thp_pkg::thp_cfg_t c);
    thp_pkg::thp_res_t r;
    logic [47:0]       inv;
    logic [11:0]       raw_temp;
    r = '0;
    if (p.row_count != thp_pkg::ROWS_EXP) begin
      r.error_code = thp_pkg::ERR_ROWS;
    end else if (p.bits_in_row != thp_pkg::PKT_LEN) begin
      r.error_code = thp_pkg::ERR_LEN;
    end else if (p.packet_bits[47:40] != c.start_byte) begin
      r.error_code = thp_pkg::ERR_START;
    end else if (crc_over_head(p.packet_bits[47:8], c) != p.packet_bits[7:0]) begin
      r.error_code = thp_pkg::ERR_CRC;
    end else begin
      inv                 = ~p.packet_bits;
      r.packet_ok         = 1'b1;
      r.error_code        = thp_pkg::ERR_OK;
      r.channel           = {1'b0, inv[34:32]} + 4'd1;
      r.sensor_number     = (inv[31:28] == thp_pkg::SENSOR_ONE_ID) ? 2'd1 : 2'd2;
      raw_temp            = inv[27:16];
      // sign-magnitude to two's complement, negative zero folds to zero
      r.temperature_tenths = raw_temp[11] ? (12'd0 - {1'b0, raw_temp[10:0]}) : raw_temp;
      r.humidity          = inv[15:8];
      r.humidity_present  = (inv[15:8] != thp_pkg::HUM_NONE);
    end
    return r;
  endfunction

  // build a well-formed packet from its decoded (inverted) body bytes
  function automatic logic [47:0] frame_reading(input logic [31:0] inv_body,
                                                 input thp_pkg::thp_cfg_t c);
    logic [39:0] head;
    head = {c.start_byte, ~inv_body};
    return {head, crc_over_head(head, c)};
  endfunction

  // random packet: mostly well-formed, some with one check broken, some noise
  function automatic thp_pkg::thp_in_t random_packet(input thp_pkg::thp_cfg_t c);
    thp_pkg::thp_in_t p;
    logic [31:0]      inv_body;
    logic [63:0]      noise;
    logic [7:0]       flip;
    int unsigned      roll;
    int unsigned      pos;
    roll     = $urandom_range(99);
    inv_body = $urandom();
    case ($urandom_range(7))
      0: inv_body[7:0]   = thp_pkg::HUM_NONE;
      1: inv_body[23:20] = thp_pkg::SENSOR_ONE_ID;
      2: inv_body[19:8]  = 12'h800;
      default: ;
    endcase
    p.row_count   = thp_pkg::ROWS_EXP;
    p.bits_in_row = thp_pkg::PKT_LEN;
    p.packet_bits = frame_reading(inv_body, c);
    flip          = 8'($urandom_range(255, 1));
    pos           = 8 + $urandom_range(31);
    if (roll >= 70 && roll < 85) begin
      case ($urandom_range(3))
        0: do p.row_count = 4'($urandom()); while (p.row_count == thp_pkg::ROWS_EXP);
        1: do p.bits_in_row = 10'($urandom()); while (p.bits_in_row == thp_pkg::PKT_LEN);
        2: p.packet_bits[47:40] = p.packet_bits[47:40] ^ flip;
        default: begin
          if ($urandom_range(1) == 0) begin
            p.packet_bits[7:0] = p.packet_bits[7:0] ^ flip;
          end else begin
            p.packet_bits[pos] = ~p.packet_bits[pos];
          end
        end
      endcase
    end else if (roll >= 85) begin
      noise         = {$urandom(), $urandom()};
      p.row_count   = ($urandom_range(1) == 0) ? thp_pkg::ROWS_EXP : 4'($urandom());
      p.bits_in_row = ($urandom_range(1) == 0) ? thp_pkg::PKT_LEN : 10'($urandom());
      p.packet_bits = noise[47:0];
    end
    return p;
  endfunction

  // one input transaction, prediction taken at the accepting edge
  task automatic send_packet(input thp_pkg::thp_in_t p);
    start <= 1'b1;
    in_i  <= p;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    expected_readings.push_back(decode_reading(p, cfg_model));
  endtask

  // random sender idle time, inputs scrambled while start is low
  task automatic sender_gap(input int unsigned idle_pct);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      in_i  <= thp_pkg::thp_in_t'(62'({$urandom(), $urandom()}));
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
  endtask

  // stop sending and let every owed reading come out
  task automatic wait_for_drain();
    start <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // apb write, junk in the upper data bits
  task automatic apb_write(input int unsigned idx, input logic [7:0] val);
    logic [31:0] noise;
    noise   = $urandom();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= thp_pkg::ADDR_W'(4 * idx);
    pwdata  <= {noise[31:8], val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      int'(thp_pkg::REG_CRC_INIT):   cfg_model.crc_init   = val;
      int'(thp_pkg::REG_CRC_POLY):   cfg_model.crc_poly   = val;
      int'(thp_pkg::REG_START_BYTE): cfg_model.start_byte = val;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // apb read compared with the register copy
  task automatic apb_read_check(input int unsigned idx, input logic [7:0] exp_val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= thp_pkg::ADDR_W'(4 * idx);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata[7:0] !== exp_val) begin
      $display("%0t register %0d readback: expected %0h, got %0h", $time, idx, exp_val,
               prdata[7:0]);
      mismatch_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_all_registers();
    apb_read_check(int'(thp_pkg::REG_CRC_INIT), cfg_model.crc_init);
    apb_read_check(int'(thp_pkg::REG_CRC_POLY), cfg_model.crc_poly);
    apb_read_check(int'(thp_pkg::REG_START_BYTE), cfg_model.start_byte);
  endtask

  task automatic apply_config(input logic [7:0] init_val, input logic [7:0] poly_val,
                              input logic [7:0] start_val);
    apb_write(int'(thp_pkg::REG_CRC_INIT), init_val);
    apb_write(int'(thp_pkg::REG_CRC_POLY), poly_val);
    apb_write(int'(thp_pkg::REG_START_BYTE), start_val);
    check_all_registers();
  endtask

  task automatic report_field(input string name, input logic [11:0] exp_val,
                              input logic [11:0] act_val);
    if (act_val !== exp_val) begin
      $display("%0t %s mismatch: expected %0h, got %0h", $time, name, exp_val, act_val);
      mismatch_count++;
    end
  endtask

  // result checker, the strobe lasts exactly one cycle
  always @(posedge clk_i) begin
    thp_pkg::thp_res_t exp_res;
    if (rst_ni && done_o) begin
      if (expected_readings.size() == 0) begin
        $display("%0t unexpected result: expected none, got %0h", $time, res_o);
        mismatch_count++;
      end else begin
        exp_res = expected_readings.pop_front();
        report_field("packet_ok", 12'(exp_res.packet_ok), 12'(res_o.packet_ok));
        report_field("error_code", 12'(exp_res.error_code), 12'(res_o.error_code));
        report_field("channel", 12'(exp_res.channel), 12'(res_o.channel));
        report_field("sensor_number", 12'(exp_res.sensor_number),
                     12'(res_o.sensor_number));
        report_field("temperature_tenths", exp_res.temperature_tenths,
                     res_o.temperature_tenths);
        report_field("humidity", 12'(exp_res.humidity), 12'(res_o.humidity));
        report_field("humidity_present", 12'(exp_res.humidity_present),
                     12'(res_o.humidity_present));
      end
    end
  end

  // registers come out of reset with their defaults
  task automatic test_reset_values();
    check_all_registers();
  endtask

  // field extremes, every error code, negative zero, missing humidity sensor
  task automatic test_directed_decoding();
    logic [47:0] good;
    good = frame_reading(32'h12_34_56_78, cfg_model);
    send_packet('{row_count: thp_pkg::ROWS_EXP, bits_in_row: thp_pkg::PKT_LEN,
                  packet_bits: frame_reading(32'h00_70_00_32, cfg_model)});
    send_packet('{row_count: thp_pkg::ROWS_EXP, bits_in_row: thp_pkg::PKT_LEN,
                  packet_bits: frame_reading(32'h07_67_ff_00, cfg_model)});
    send_packet('{row_count: thp_pkg::ROWS_EXP, bits_in_row: thp_pkg::PKT_LEN,
                  packet_bits: frame_reading(32'hf8_7f_ff_ff, cfg_model)});
    send_packet('{row_count: thp_pkg::ROWS_EXP, bits_in_row: thp_pkg::PKT_LEN,
                  packet_bits: frame_reading(32'h03_f8_00_64, cfg_model)});
    send_packet('{row_count: thp_pkg::ROWS_EXP, bits_in_row: thp_pkg::PKT_LEN,
                  packet_bits: frame_reading(32'h05_02_9a_fe, cfg_model)});
    send_packet('{row_count: thp_pkg::ROWS_EXP, bits_in_row: thp_pkg::PKT_LEN,
                  packet_bits: good});
    // row count errors, rows checked before length
    send_packet('{row_count: 4'd0, bits_in_row: thp_pkg::PKT_LEN, packet_bits: good});
    send_packet('{row_count: 4'd1, bits_in_row: thp_pkg::PKT_LEN, packet_bits: good});
    send_packet('{row_count: 4'd3, bits_in_row: 10'd0, packet_bits: good});
    send_packet('{row_count: 4'd15, bits_in_row: 10'd1023, packet_bits: 48'hffff_ffff_ffff});
    // length errors
    send_packet('{row_count: thp_pkg::ROWS_EXP, bits_in_row: 10'd0, packet_bits: good});
    send_packet('{row_count: thp_pkg::ROWS_EXP, bits_in_row: 10'd47, packet_bits: good});
    send_packet('{row_count: thp_pkg::ROWS_EXP, bits_in_row: 10'd49, packet_bits: good});
    send_packet('{row_count: thp_pkg::ROWS_EXP, bits_in_row: 10'd1023, packet_bits: good});
    // start byte errors, start checked before crc
    send_packet('{row_count: thp_pkg::ROWS_EXP, bits_in_row: thp_pkg::PKT_LEN,
                  packet_bits: good ^ {8'h01, 40'h0}});
    send_packet('{row_count: thp_pkg::ROWS_EXP, bits_in_row: thp_pkg::PKT_LEN,
                  packet_bits: good ^ {8'h80, 32'h0, 8'h01}});
    send_packet('{row_count: thp_pkg::ROWS_EXP, bits_in_row: thp_pkg::PKT_LEN,
                  packet_bits: 48'hffff_ffff_ffff});
    // crc errors
    send_packet('{row_count: thp_pkg::ROWS_EXP, bits_in_row: thp_pkg::PKT_LEN,
                  packet_bits: good ^ 48'h1});
    send_packet('{row_count: thp_pkg::ROWS_EXP, bits_in_row: thp_pkg::PKT_LEN,
                  packet_bits: good ^ 48'hff});
    send_packet('{row_count: thp_pkg::ROWS_EXP, bits_in_row: thp_pkg::PKT_LEN,
                  packet_bits: good ^ (48'h1 << 20)});
    send_packet('{row_count: thp_pkg::ROWS_EXP, bits_in_row: thp_pkg::PKT_LEN,
                  packet_bits: 48'h0});
    wait_for_drain();
  endtask

  // a write past the last register changes nothing
  task automatic test_unmapped_register();
    apb_write(UNMAPPED_REG, 8'h5a);
    check_all_registers();
    send_packet('{row_count: thp_pkg::ROWS_EXP, bits_in_row: thp_pkg::PKT_LEN,
                  packet_bits: frame_reading(32'h01_23_45_67, cfg_model)});
    wait_for_drain();
  endtask

  // random packets under one register setting, with a full drain halfway
  task automatic test_random_traffic(input int unsigned count, input int unsigned idle_pct,
                                     input logic [7:0] init_val, input logic [7:0] poly_val,
                                     input logic [7:0] start_val);
    apply_config(init_val, poly_val, start_val);
    for (int unsigned n = 0; n < count; n++) begin
      send_packet(random_packet(cfg_model));
      if (n == count / 2) begin
        wait_for_drain();
      end else begin
        sender_gap(idle_pct);
      end
    end
    wait_for_drain();
  endtask

  // sequence of tests
  initial begin
    int unsigned waited;
    rst_ni         <= 1'b0;
    start          <= 1'b0;
    in_i           <= '0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    mismatch_count = 0;
    cfg_model      = '{crc_init: thp_pkg::CRC_INIT_RST, crc_poly: thp_pkg::CRC_POLY_RST,
                       start_byte: thp_pkg::START_BYTE_RST};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_values();
    test_directed_decoding();
    test_unmapped_register();
    test_random_traffic(250, 7, thp_pkg::CRC_INIT_RST, thp_pkg::CRC_POLY_RST,
                        thp_pkg::START_BYTE_RST);
    test_random_traffic(230, 7, 8'h00, 8'h00, 8'h00);
    test_random_traffic(230, 83, 8'hff, 8'hff, 8'hff);
    test_random_traffic(230, 83, 8'($urandom()), 8'($urandom()), 8'($urandom()));
    test_random_traffic(230, 0, 8'($urandom()), 8'($urandom()), 8'($urandom()));
    test_random_traffic(230, 0, 8'h00, 8'hff, 8'h80);

    // final drain with a bound
    start  <= 1'b0;
    waited = 0;
    while (expected_readings.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (expected_readings.size() != 0) begin
      $display("%0t missing results: expected %0d more, got none", $time,
               expected_readings.size());
      mismatch_count += expected_readings.size();
    end

    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
